[sv/rbf_pkg.sv]
// Shared types, register and face codes for the ray/box face intersect core.
// No dependencies; imported by the core and its checker.
package rbf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int UV_BITS = 16;
  localparam logic signed [31:0] BOX_MAX_RESET = 32'sh0001_0000;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X,
    REG_BOX_MIN_Y,
    REG_BOX_MIN_Z,
    REG_BOX_MAX_X,
    REG_BOX_MAX_Y,
    REG_BOX_MAX_Z
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FACE_ZMAX,
    FACE_ZMIN,
    FACE_YMAX,
    FACE_YMIN,
    FACE_XMAX,
    FACE_XMIN
  } face_code_t;

  // plane axis and the two in-face axes of each face (0 x, 1 y, 2 z)
  localparam int FACE_AXIS [6] = '{2, 2, 1, 1, 0, 0};
  localparam int FACE_UA   [6] = '{0, 0, 0, 0, 1, 1};
  localparam int FACE_VA   [6] = '{1, 1, 2, 2, 2, 2};

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [31:0]      tlo;
    logic [31:0]      tup;
  } ray_t;

  function automatic int core_latency(int frac_bits);
    return (34 + frac_bits) + 5 + (UV_BITS + 2) + 1;
  endfunction

endpackage

[sv/rbf_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; used by ray_box_face_intersect_core.
module rbf_div #(
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] num_q [QW+1];
  logic [DW-1:0] den_q [QW];

  always_ff @(posedge clk) begin
    rem_q[0] <= rem_in;
    num_q[0] <= num_in;
    den_q[0] <= den_in;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_q[i], num_q[i][QW-1]};
    assign ge    = trial >= {1'b0, den_q[i]};
    always_ff @(posedge clk) begin
      num_q[i+1] <= {num_q[i][QW-2:0], ge};
    end
    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[i+1] <= ge ? DW'(trial - {1'b0, den_q[i]}) : trial[DW-1:0];
        den_q[i+1] <= den_q[i];
      end
    end
  end

  assign quo = num_q[QW];

endmodule

[sv/ray_box_face_intersect_core.sv]
// Ray against axis-aligned box, six faces tested per ray, fully pipelined.
// The t divider (33 + FRAC_BITS stages) and the 17-stage u/v divider each
// resolve one quotient bit per stage.
// Throughput: one ray per cycle; busy stays low and done pulses once per ray.
// Reset (rst, synchronous): box corners to 0 / 1.0 in Q16.16, all in-flight beats dropped.
// Depends on rbf_pkg and rbf_div.
module ray_box_face_intersect_core #(
  parameter int FRAC_BITS = rbf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] ray_origin_x,
  input  logic signed [31:0] ray_origin_y,
  input  logic signed [31:0] ray_origin_z,
  input  logic signed [31:0] ray_dir_x,
  input  logic signed [31:0] ray_dir_y,
  input  logic signed [31:0] ray_dir_z,
  input  logic signed [31:0] t_lower,
  input  logic signed [31:0] t_upper,
  output logic               done,
  output logic               hit_found,
  output logic [2:0]         face_index,
  output logic signed [31:0] hit_t,
  output logic [16:0]        face_u,
  output logic [16:0]        face_v,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               front_face
);
  import rbf_pkg::*;

  localparam int QW_T  = 33 + FRAC_BITS;   // t quotient width
  localparam int LT    = QW_T + 1;         // t divider depth, input register included
  localparam int CW    = 65 - FRAC_BITS;   // wide coordinate width
  localparam int QW_UV = UV_BITS + 1;
  localparam int LUV   = QW_UV + 1;
  localparam logic signed [CW-1:0] PMAX = CW'(32'sh7fff_ffff);
  localparam logic signed [CW-1:0] PMIN = CW'(32'sh8000_0000);

  typedef struct packed {
    logic                 ok;
    logic signed [31:0]   t;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic                 front;
    logic [31:0]          du;
    logic [31:0]          su;
    logic                 pu;
    logic [31:0]          dv;
    logic [31:0]          sv;
    logic                 pv;
  } face_t;

  typedef struct packed {
    logic                 found;
    face_code_t           face;
    logic signed [31:0]   t;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic                 front;
    logic [31:0]          du;
    logic [31:0]          su;
    logic                 pu;
    logic [31:0]          dv;
    logic [31:0]          sv;
    logic                 pv;
  } sel_t;

  // Take a later face when it is valid and no farther than the best so far.
  function automatic sel_t pick(sel_t s, face_t fc, face_code_t idx);
    sel_t r;
    r = s;
    if (fc.ok && (fc.t <= s.t)) begin
      r.found = 1'b1;
      r.face  = idx;
      r.t     = fc.t;
      r.cx    = fc.cx;
      r.cy    = fc.cy;
      r.cz    = fc.cz;
      r.front = fc.front;
      r.du    = fc.du;
      r.su    = fc.su;
      r.pu    = fc.pu;
      r.dv    = fc.dv;
      r.sv    = fc.sv;
      r.pv    = fc.pv;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_t(logic neg, logic [QW_T-1:0] q);
    logic signed [31:0] r;
    if (neg) begin
      r = (q > QW_T'(33'h0_8000_0000)) ? 32'sh8000_0000 : 32'(-q);
    end else begin
      r = (q > QW_T'(32'h7fff_ffff)) ? 32'sh7fff_ffff : q[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_c(logic signed [CW-1:0] c);
    logic signed [31:0] r;
    if (c > PMAX) begin
      r = 32'sh7fff_ffff;
    end else if (c < PMIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = c[31:0];
    end
    return r;
  endfunction

  // every cycle takes a beat; the receiver cannot stall
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- box registers ----------------
  logic signed [31:0] bmin [3];
  logic signed [31:0] bmax [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= '0;
        bmax[i] <= BOX_MAX_RESET;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_BOX_MIN_X: bmin[0] <= wr_data;
        REG_BOX_MIN_Y: bmin[1] <= wr_data;
        REG_BOX_MIN_Z: bmin[2] <= wr_data;
        REG_BOX_MAX_X: bmax[0] <= wr_data;
        REG_BOX_MAX_Y: bmax[1] <= wr_data;
        REG_BOX_MAX_Z: bmax[2] <= wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  ray_t ray_in;
  assign ray_in.o   = {ray_origin_z, ray_origin_y, ray_origin_x};
  assign ray_in.d   = {ray_dir_z, ray_dir_y, ray_dir_x};
  assign ray_in.tlo = t_lower;
  assign ray_in.tup = t_upper;

  // ---------------- t = (k - o) << F / d, one divider per face ----------------
  logic [QW_T-1:0] quo_t [6];
  logic [5:0]      neg_in;

  for (genvar f = 0; f < 6; f++) begin : g_tdiv
    localparam int AX = FACE_AXIS[f];
    logic signed [32:0] kdiff;
    logic [32:0]        kmag;
    logic [31:0]        dmag;
    if (f % 2 == 0) begin : g_kmax
      assign kdiff = {bmax[AX][31], bmax[AX]} - {ray_in.o[AX][31], ray_in.o[AX]};
    end else begin : g_kmin
      assign kdiff = {bmin[AX][31], bmin[AX]} - {ray_in.o[AX][31], ray_in.o[AX]};
    end
    assign kmag      = kdiff[32] ? 33'(-kdiff) : kdiff;
    assign dmag      = ray_in.d[AX][31] ? 32'(-ray_in.d[AX]) : ray_in.d[AX];
    assign neg_in[f] = kdiff[32] ^ ray_in.d[AX][31];

    rbf_div #(.DW(32), .QW(QW_T)) u_tdiv (
      .clk    (clk),
      .rem_in ('0),
      .num_in ({kmag, {FRAC_BITS{1'b0}}}),
      .den_in (dmag),
      .quo    (quo_t[f])
    );
  end

  // hold ray data alongside the t dividers
  ray_t       dly_ray [LT];
  logic [5:0] dly_neg [LT];
  logic       dly_vld [LT];

  always_ff @(posedge clk) begin
    dly_ray[0] <= ray_in;
    dly_neg[0] <= neg_in;
    for (int i = 1; i < LT; i++) begin
      dly_ray[i] <= dly_ray[i-1];
      dly_neg[i] <= dly_neg[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LT; i++) dly_vld[i] <= 1'b0;
    end else begin
      dly_vld[0] <= accept;
      for (int i = 1; i < LT; i++) dly_vld[i] <= dly_vld[i-1];
    end
  end

  // ---------------- stage B: saturate t, flag zero directions ----------------
  ray_t               ray_b;
  logic signed [31:0] t_b [6];
  logic [5:0]         bad_b;
  logic               vld_b;

  always_ff @(posedge clk) begin
    ray_b <= dly_ray[LT-1];
    for (int f = 0; f < 6; f++) begin
      t_b[f]   <= sat_t(dly_neg[LT-1][f], quo_t[f]);
      bad_b[f] <= (dly_ray[LT-1].d[FACE_AXIS[f]] == '0);
    end
  end

  // ---------------- stage C: t * d products ----------------
  ray_t               ray_c;
  logic signed [31:0] t_c [6];
  logic [5:0]         bad_c;
  logic               vld_c;
  logic signed [63:0] prod_c [6][3];

  always_ff @(posedge clk) begin
    ray_c <= ray_b;
    bad_c <= bad_b;
    for (int f = 0; f < 6; f++) begin
      t_c[f] <= t_b[f];
      for (int i = 0; i < 3; i++) begin
        prod_c[f][i] <= t_b[f] * $signed(ray_b.d[i]);
      end
    end
  end

  // ---------------- stage D: hit point, inside test, face fractions setup ----------------
  face_t              fd [6];
  logic signed [31:0] tup_d;
  logic               vld_d;

  for (genvar f = 0; f < 6; f++) begin : g_face
    localparam int AX = FACE_AXIS[f];
    localparam int UA = FACE_UA[f];
    localparam int VA = FACE_VA[f];
    logic signed [CW-1:0] c [3];
    logic signed [CW-1:0] lo_u, hi_u, lo_v, hi_v, du_w, dv_w;
    logic signed [32:0]   su_w, sv_w;
    logic                 in_u, in_v, t_in;
    face_t                fnext;

    for (genvar i = 0; i < 3; i++) begin : g_axis
      assign c[i] = CW'($signed(ray_c.o[i])) + CW'(prod_c[f][i] >>> FRAC_BITS);
    end

    assign lo_u = CW'(bmin[UA]);
    assign hi_u = CW'(bmax[UA]);
    assign lo_v = CW'(bmin[VA]);
    assign hi_v = CW'(bmax[VA]);
    assign in_u = (c[UA] >= lo_u) && (c[UA] <= hi_u);
    assign in_v = (c[VA] >= lo_v) && (c[VA] <= hi_v);
    assign t_in = t_c[f] >= $signed(ray_c.tlo);
    assign du_w = c[UA] - lo_u;
    assign dv_w = c[VA] - lo_v;
    assign su_w = {bmax[UA][31], bmax[UA]} - {bmin[UA][31], bmin[UA]};
    assign sv_w = {bmax[VA][31], bmax[VA]} - {bmin[VA][31], bmin[VA]};

    always_comb begin
      fnext.ok    = !bad_c[f] && t_in && in_u && in_v;
      fnext.t     = t_c[f];
      fnext.cx    = c[0];
      fnext.cy    = c[1];
      fnext.cz    = c[2];
      fnext.front = ray_c.d[AX][31];
      fnext.du    = du_w[31:0];
      fnext.su    = su_w[31:0];
      fnext.pu    = su_w > 33'sd0;
      fnext.dv    = dv_w[31:0];
      fnext.sv    = sv_w[31:0];
      fnext.pv    = sv_w > 33'sd0;
    end

    always_ff @(posedge clk) begin
      fd[f] <= fnext;
    end
  end

  always_ff @(posedge clk) begin
    tup_d <= ray_c.tup;
  end

  // ---------------- stages E1/E2: nearest face, z faces first ----------------
  sel_t  s_init, s_e1, s_e2;
  face_t fh [3];
  logic  vld_e1, vld_e2;

  always_comb begin
    s_init       = '0;
    s_init.t     = tup_d;
    s_init.face  = FACE_ZMAX;
  end

  always_ff @(posedge clk) begin
    s_e1 <= pick(pick(pick(s_init, fd[0], FACE_ZMAX), fd[1], FACE_ZMIN), fd[2], FACE_YMAX);
    for (int i = 0; i < 3; i++) fh[i] <= fd[3 + i];
    s_e2 <= pick(pick(pick(s_e1, fh[0], FACE_YMIN), fh[1], FACE_XMAX), fh[2], FACE_XMIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b  <= 1'b0;
      vld_c  <= 1'b0;
      vld_d  <= 1'b0;
      vld_e1 <= 1'b0;
      vld_e2 <= 1'b0;
    end else begin
      vld_b  <= dly_vld[LT-1];
      vld_c  <= vld_b;
      vld_d  <= vld_c;
      vld_e1 <= vld_d;
      vld_e2 <= vld_e1;
    end
  end

  // ---------------- u/v fractions of the winning face ----------------
  logic [QW_UV-1:0] quo_u, quo_v;

  rbf_div #(.DW(32), .QW(QW_UV)) u_udiv (
    .clk    (clk),
    .rem_in ({1'b0, s_e2.du[31:1]}),
    .num_in ({s_e2.du[0], {UV_BITS{1'b0}}}),
    .den_in (s_e2.su),
    .quo    (quo_u)
  );

  rbf_div #(.DW(32), .QW(QW_UV)) u_vdiv (
    .clk    (clk),
    .rem_in ({1'b0, s_e2.dv[31:1]}),
    .num_in ({s_e2.dv[0], {UV_BITS{1'b0}}}),
    .den_in (s_e2.sv),
    .quo    (quo_v)
  );

  sel_t uv_dly [LUV];
  logic uv_vld [LUV];

  always_ff @(posedge clk) begin
    uv_dly[0] <= s_e2;
    for (int i = 1; i < LUV; i++) uv_dly[i] <= uv_dly[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LUV; i++) uv_vld[i] <= 1'b0;
    end else begin
      uv_vld[0] <= vld_e2;
      for (int i = 1; i < LUV; i++) uv_vld[i] <= uv_vld[i-1];
    end
  end

  // ---------------- result register: a miss reports all zeros ----------------
  sel_t s_out;
  assign s_out = uv_dly[LUV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= uv_vld[LUV-1];
    end
  end

  always_ff @(posedge clk) begin
    hit_found  <= s_out.found;
    face_index <= s_out.found ? s_out.face : 3'd0;
    hit_t      <= s_out.found ? s_out.t : 32'sd0;
    face_u     <= (s_out.found && s_out.pu) ? quo_u : '0;
    face_v     <= (s_out.found && s_out.pv) ? quo_v : '0;
    point_x    <= s_out.found ? sat_c(s_out.cx) : 32'sd0;
    point_y    <= s_out.found ? sat_c(s_out.cy) : 32'sd0;
    point_z    <= s_out.found ? sat_c(s_out.cz) : 32'sd0;
    front_face <= s_out.found && s_out.front;
  end

endmodule

[sv/rbf_check.sv]
// Port-level checker for ray_box_face_intersect_core, attached by bind.
// Depends on rbf_pkg for the pipeline latency.
module rbf_check #(
  parameter int FRAC_BITS = rbf_pkg::FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               hit_found,
  input logic [2:0]         face_index,
  input logic signed [31:0] hit_t,
  input logic [16:0]        face_u,
  input logic [16:0]        face_v,
  input logic               front_face
);
  import rbf_pkg::*;

  localparam int LAT = core_latency(FRAC_BITS);

  // a result beat only ever follows an accepted ray by the fixed latency
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start, LAT) && !$past(busy, LAT)))
    else $error("result beat without a matching ray");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit_found) |-> (face_index == 3'd0 && hit_t == 32'sd0 &&
                              face_u == 17'd0 && face_v == 17'd0 && !front_face))
    else $error("miss beat with non-zero fields");

  a_face_code: assert property (@(posedge clk) disable iff (rst)
    (done && hit_found) |-> (face_index <= 3'd5))
    else $error("face index out of range");

  a_uv_range: assert property (@(posedge clk) disable iff (rst)
    (done && hit_found) |-> (face_u <= 17'd65536 && face_v <= 17'd65536))
    else $error("face fraction above one");

endmodule

bind ray_box_face_intersect_core rbf_check #(.FRAC_BITS(FRAC_BITS)) u_rbf_check (.*);
